// ===== sv/nsts_pkg.sv =====
// nsts_pkg: shared types, geometry constants and index helpers for the n-ary sum tree sampler
// used by nary_sum_tree_sampler_top; no dependencies
package nsts_pkg;

  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned BRANCH    = 4;
  localparam int unsigned BRANCH_W  = $clog2(BRANCH);
  localparam int unsigned LEVELS    = (BRANCH_W == 0) ? 1 : ($clog2(LEAVES) + BRANCH_W - 1) / BRANCH_W;
  localparam int unsigned LAST      = BRANCH ** LEVELS;
  localparam int unsigned LEAF_BASE = (LAST - 1) / (BRANCH - 1);
  localparam int unsigned NODES     = (LAST * BRANCH - 1) / (BRANCH - 1);
  localparam int unsigned ADDR_W    = $clog2(NODES);
  localparam int unsigned LEAF_W    = $clog2(LEAVES);
  localparam int unsigned CNT_W     = $clog2(LEAVES + 1);
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned PRIO_W    = 32;
  localparam int unsigned PART_W    = SUM_W + BRANCH_W;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_RANGE  = 2'd2,
    ACT_SEARCH = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_WRITE,
    ST_READ,
    ST_PFX_SET,
    ST_PFX,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e            action;
    logic [LEAF_W-1:0]  leaf_index;
    logic [SUM_W-1:0]   amount;
    logic [CNT_W-1:0]   range_start;
    logic [CNT_W-1:0]   range_end;
  } req_t;

  typedef struct packed {
    logic [LEAF_W-1:0]  found_index;
    logic [SUM_W-1:0]   sum_value;
    logic               status;
  } rsp_t;

  // parent of a non-root node
  function automatic addr_t parent_of(addr_t n);
    addr_t m;
    m = n - addr_t'(1);
    return m >> BRANCH_W;
  endfunction

  // first node among the siblings of a non-root node
  function automatic addr_t group_first(addr_t n);
    addr_t m;
    m = n - addr_t'(1);
    return ((m >> BRANCH_W) << BRANCH_W) + addr_t'(1);
  endfunction

endpackage

// ===== sv/nary_sum_tree_sampler_top.sv =====
// n-ary sum tree sampler: one node ram walked by a sequencer, one transaction at a time
// a transaction is accepted only in idle and runs to done; the next one is taken after the result
// has moved into the output register, which holds the sequencer in done while it is still full
// the node ram read port sets the pace; a result waits in an output register
// after reset a clearing pass zeroes every node of the tree, in_ready_o low meanwhile
// depends on nsts_pkg and nsts_ram
module nary_sum_tree_sampler_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  nsts_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output nsts_pkg::rsp_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic [nsts_pkg::CNT_W-1:0] cfg_wdata_i
);

  localparam nsts_pkg::addr_t LeafBaseA = nsts_pkg::addr_t'(nsts_pkg::LEAF_BASE);
  localparam nsts_pkg::addr_t LastNodeA = nsts_pkg::addr_t'(nsts_pkg::NODES - 1);
  localparam logic [nsts_pkg::CNT_W-1:0] LeavesC = nsts_pkg::CNT_W'(nsts_pkg::LEAVES);
  localparam logic [nsts_pkg::BRANCH_W-1:0] LastChildC =
    nsts_pkg::BRANCH_W'(nsts_pkg::BRANCH - 1);

  nsts_pkg::state_e state_q, state_d;
  nsts_pkg::req_t   req_q, req_d;
  nsts_pkg::rsp_t   res_q, res_d;
  nsts_pkg::rsp_t   out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [nsts_pkg::CNT_W-1:0]    ent_q;
  logic [nsts_pkg::CNT_W-1:0]    used;
  nsts_pkg::addr_t               node_q, node_d;
  nsts_pkg::addr_t               sib_q, sib_d;
  nsts_pkg::addr_t               clr_q, clr_d;
  logic                          pend_q, pend_d;
  logic                          pass_q, pass_d;
  logic [nsts_pkg::SUM_W-1:0]    acc_q, acc_d;
  logic [nsts_pkg::SUM_W-1:0]    pfx_q, pfx_d;
  logic [nsts_pkg::SUM_W-1:0]    delta_q, delta_d;
  logic [nsts_pkg::SUM_W-1:0]    target_q, target_d;
  logic [nsts_pkg::PART_W-1:0]   partial_q, partial_d;
  logic [nsts_pkg::BRANCH_W-1:0] jidx_q, jidx_d;

  logic                          ram_we, ram_re;
  nsts_pkg::addr_t               ram_waddr, ram_raddr;
  logic [nsts_pkg::SUM_W-1:0]    ram_wdata, ram_rdata;

  logic [nsts_pkg::SUM_W-1:0]    prio;
  logic [nsts_pkg::CNT_W-1:0]    pfx_end;
  logic [nsts_pkg::PART_W-1:0]   after;
  logic                          take;
  nsts_pkg::addr_t               up_node, up_first, leaf_node;

  nsts_ram #(
    .Width(nsts_pkg::SUM_W),
    .Depth(nsts_pkg::NODES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign used = (ent_q == '0) ? nsts_pkg::CNT_W'(1) : ((ent_q > LeavesC) ? LeavesC : ent_q);
  assign prio = (|req_q.amount[nsts_pkg::SUM_W-1:nsts_pkg::PRIO_W])
              ? nsts_pkg::SUM_W'({nsts_pkg::PRIO_W{1'b1}}) : req_q.amount;
  assign pfx_end   = pass_q ? req_q.range_start : req_q.range_end;
  assign after     = partial_q + nsts_pkg::PART_W'(ram_rdata);
  assign take      = (after >= nsts_pkg::PART_W'(target_q)) || (jidx_q == LastChildC);
  assign up_node   = nsts_pkg::parent_of(node_q);
  assign up_first  = nsts_pkg::group_first(up_node);
  assign leaf_node = LeafBaseA + nsts_pkg::addr_t'(pfx_end);

  assign in_ready_o  = (state_q == nsts_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nsts_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      ent_q       <= LeavesC;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      pass_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      pend_q      <= pend_d;
      pass_q      <= pass_d;
      if (cfg_we_i) begin
        ent_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    res_q     <= res_d;
    out_q     <= out_d;
    node_q    <= node_d;
    sib_q     <= sib_d;
    acc_q     <= acc_d;
    pfx_q     <= pfx_d;
    delta_q   <= delta_d;
    target_q  <= target_d;
    partial_q <= partial_d;
    jidx_q    <= jidx_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    node_d      = node_q;
    sib_d       = sib_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    pass_d      = pass_q;
    acc_d       = acc_q;
    pfx_d       = pfx_q;
    delta_d     = delta_q;
    target_d    = target_q;
    partial_d   = partial_q;
    jidx_d      = jidx_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = node_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      nsts_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + nsts_pkg::addr_t'(1);
        if (clr_q == LastNodeA) begin
          state_d = nsts_pkg::ST_IDLE;
        end
      end

      nsts_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = nsts_pkg::ST_START;
        end
      end

      nsts_pkg::ST_START: begin
        res_d = '0;
        unique case (req_q.action)
          nsts_pkg::ACT_WRITE, nsts_pkg::ACT_READ: begin
            if (nsts_pkg::CNT_W'(req_q.leaf_index) >= used) begin
              res_d.status = 1'b1;
              state_d      = nsts_pkg::ST_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = LeafBaseA + nsts_pkg::addr_t'(req_q.leaf_index);
              node_d    = ram_raddr;
              pend_d    = 1'b1;
              state_d   = (req_q.action == nsts_pkg::ACT_WRITE)
                        ? nsts_pkg::ST_WRITE : nsts_pkg::ST_READ;
            end
          end
          nsts_pkg::ACT_RANGE: begin
            if ((req_q.range_end > used) || (req_q.range_start > req_q.range_end)) begin
              res_d.status = 1'b1;
              state_d      = nsts_pkg::ST_DONE;
            end else begin
              pass_d  = 1'b0;
              state_d = nsts_pkg::ST_PFX_SET;
            end
          end
          nsts_pkg::ACT_SEARCH: begin
            ram_re    = 1'b1;
            ram_raddr = nsts_pkg::addr_t'(1);
            node_d    = nsts_pkg::addr_t'(1);
            jidx_d    = '0;
            partial_d = '0;
            target_d  = req_q.amount;
            state_d   = nsts_pkg::ST_SEARCH;
          end
          default: state_d = nsts_pkg::ST_DONE;
        endcase
      end

      nsts_pkg::ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        pend_d    = 1'b0;
        if (pend_q) begin
          ram_wdata = prio;
          delta_d   = prio - ram_rdata;
        end else begin
          ram_wdata = ram_rdata + delta_q;
        end
        if (node_q == '0) begin
          state_d = nsts_pkg::ST_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = up_node;
          node_d    = up_node;
        end
      end

      nsts_pkg::ST_READ: begin
        pend_d          = 1'b0;
        res_d.sum_value = ram_rdata;
        state_d         = nsts_pkg::ST_DONE;
      end

      nsts_pkg::ST_PFX_SET: begin
        acc_d  = '0;
        pend_d = 1'b0;
        if (pfx_end == '0) begin
          node_d = '0;
        end else if (pfx_end >= used) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          node_d    = '0;
          pend_d    = 1'b1;
        end else begin
          node_d = leaf_node;
          sib_d  = nsts_pkg::group_first(leaf_node);
        end
        state_d = nsts_pkg::ST_PFX;
      end

      nsts_pkg::ST_PFX: begin
        pend_d = 1'b0;
        if (pend_q) begin
          acc_d = acc_q + ram_rdata;
        end
        if (node_q == '0) begin
          if (!pend_q) begin
            if (!pass_q) begin
              pfx_d   = acc_q;
              pass_d  = 1'b1;
              state_d = nsts_pkg::ST_PFX_SET;
            end else begin
              res_d.sum_value = pfx_q - acc_q;
              state_d         = nsts_pkg::ST_DONE;
            end
          end
        end else if (sib_q < node_q) begin
          ram_re    = 1'b1;
          ram_raddr = sib_q;
          sib_d     = sib_q + nsts_pkg::addr_t'(1);
          pend_d    = 1'b1;
        end else begin
          node_d = up_node;
          sib_d  = up_first;
          if ((up_node != '0) && (up_first < up_node)) begin
            ram_re    = 1'b1;
            ram_raddr = up_first;
            sib_d     = up_first + nsts_pkg::addr_t'(1);
            pend_d    = 1'b1;
          end
        end
      end

      nsts_pkg::ST_SEARCH: begin
        if (!take) begin
          partial_d = after;
          node_d    = node_q + nsts_pkg::addr_t'(1);
          jidx_d    = jidx_q + nsts_pkg::BRANCH_W'(1);
          ram_re    = 1'b1;
          ram_raddr = node_d;
        end else if (node_q < LeafBaseA) begin
          target_d  = target_q - partial_q[nsts_pkg::SUM_W-1:0];
          partial_d = '0;
          jidx_d    = '0;
          node_d    = (node_q << nsts_pkg::BRANCH_W) + nsts_pkg::addr_t'(1);
          ram_re    = 1'b1;
          ram_raddr = node_d;
        end else begin
          res_d.found_index = nsts_pkg::LEAF_W'(node_q - LeafBaseA);
          if (nsts_pkg::CNT_W'(node_q - LeafBaseA) >= used) begin
            res_d.found_index = nsts_pkg::LEAF_W'(used - nsts_pkg::CNT_W'(1));
            res_d.status      = 1'b1;
          end
          state_d = nsts_pkg::ST_DONE;
        end
      end

      nsts_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = nsts_pkg::ST_IDLE;
        end
      end

      default: state_d = nsts_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== sv/nsts_ram.sv =====
// nsts_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module nsts_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 1365
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/sum_tree_checker.sv =====
`timescale 1ns / 100ps
// sum_tree_checker: watches the request, response and register ports of the sum tree sampler,
// keeps its own copy of the node sums and compares every response with the predicted one
// depends on nsts_pkg
module sum_tree_checker
  import nsts_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  req_t             in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  rsp_t             out_data_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output int unsigned      pending_o,
  output int unsigned      fail_count_o
);

  typedef logic [SUM_W-1:0] sum_t;

  sum_t             node_sum [NODES];
  logic [CNT_W-1:0] entries_reg;
  rsp_t             predicted_rsp [$];
  rsp_t             want;
  int unsigned      new_fails;

  function automatic int unsigned leaves_in_use();
    if (entries_reg == '0) return 1;
    if (entries_reg > LEAVES) return LEAVES;
    return entries_reg;
  endfunction

  // sum of leaves below upto, walking up and adding left siblings
  function automatic sum_t prefix_mass(int unsigned upto, int unsigned used);
    int unsigned node;
    int unsigned up;
    int unsigned c;
    sum_t        acc;
    acc = '0;
    if (upto == 0) return '0;
    if (upto >= used) return node_sum[0];
    node = LEAF_BASE + upto;
    while (node != 0) begin
      up = (node - 1) / BRANCH;
      for (c = up * BRANCH + 1; c < node; c++) acc += node_sum[c];
      node = up;
    end
    return acc;
  endfunction

  function automatic rsp_t predict_rsp(req_t req);
    rsp_t              rsp;
    int unsigned       used;
    int unsigned       node;
    int unsigned       j;
    logic [PRIO_W-1:0] prio;
    sum_t              delta;
    sum_t              target;
    logic [PART_W-1:0] partial;
    logic [PART_W-1:0] after;
    rsp  = '0;
    used = leaves_in_use();
    case (req.action)
      ACT_WRITE: begin
        if (req.leaf_index >= used) begin
          rsp.status = 1'b1;
        end else begin
          prio  = (req.amount[SUM_W-1:PRIO_W] != '0) ? '1 : req.amount[PRIO_W-1:0];
          node  = LEAF_BASE + req.leaf_index;
          delta = sum_t'(prio) - node_sum[node];
          forever begin
            node_sum[node] += delta;
            if (node == 0) break;
            node = (node - 1) / BRANCH;
          end
        end
      end
      ACT_READ: begin
        if (req.leaf_index >= used) rsp.status = 1'b1;
        else rsp.sum_value = node_sum[LEAF_BASE + req.leaf_index];
      end
      ACT_RANGE: begin
        if (req.range_end > used || req.range_start > req.range_end) rsp.status = 1'b1;
        else rsp.sum_value = prefix_mass(req.range_end, used) - prefix_mass(req.range_start, used);
      end
      ACT_SEARCH: begin
        node   = 0;
        target = req.amount;
        while (node < LEAF_BASE) begin
          partial = '0;
          node    = node * BRANCH + 1;
          for (j = 0; j < BRANCH; j++) begin
            after = partial + node_sum[node];
            if (after >= target || j + 1 == BRANCH) break;
            partial = after;
            node++;
          end
          // past the total the last child is taken and only earlier siblings are removed
          target = (target >= partial) ? target - sum_t'(partial) : '0;
        end
        if (node - LEAF_BASE >= used) begin
          rsp.found_index = LEAF_W'(used - 1);
          rsp.status      = 1'b1;
        end else begin
          rsp.found_index = LEAF_W'(node - LEAF_BASE);
        end
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (node_sum[i]) node_sum[i] = '0;
      entries_reg = CNT_W'(LEAVES);
      predicted_rsp.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      new_fails = 0;
      if (in_valid_i && in_ready_i) predicted_rsp.push_back(predict_rsp(in_data_i));
      if (cfg_we_i) entries_reg = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: response with none outstanding, actual %p", $time, out_data_i);
          new_fails++;
        end else begin
          want = predicted_rsp.pop_front();
          if (out_data_i.found_index !== want.found_index) begin
            $display("%0t: found_index mismatch, expected %0d, actual %0d",
                     $time, want.found_index, out_data_i.found_index);
            new_fails++;
          end
          if (out_data_i.sum_value !== want.sum_value) begin
            $display("%0t: sum_value mismatch, expected 0x%0h, actual 0x%0h",
                     $time, want.sum_value, out_data_i.sum_value);
            new_fails++;
          end
          if (out_data_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, out_data_i.status);
            new_fails++;
          end
        end
      end
      pending_o    <= predicted_rsp.size();
      fail_count_o <= fail_count_o + new_fails;
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives requests, leaf-count register writes and response back-pressure into the
// sum tree sampler; depends on nsts_pkg, nary_sum_tree_sampler_top and sum_tree_checker
module testbench;
  import nsts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  req_t             in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  rsp_t             out_data_o;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  int unsigned       pending;
  int unsigned       fail_count;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  int unsigned       cycles;
  int unsigned       entries_used;
  int unsigned       settings_done;
  int unsigned       sent_by_action [4];
  logic [PRIO_W-1:0] leaf_prio [LEAVES];
  logic [63:0]       total_mass;
  int unsigned       phase_items   [6] = '{300, 100, 300, 100, 350, 350};
  int unsigned       phase_entries [6] = '{16, 0, 2047, 1, 0, 1024};

  nary_sum_tree_sampler_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sum_tree_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    cycles      <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic req_t make_req(action_e act, int unsigned leaf, logic [SUM_W-1:0] amt,
                                    int unsigned rs, int unsigned re);
    req_t r;
    r.action      = act;
    r.leaf_index  = LEAF_W'(leaf);
    r.amount      = amt;
    r.range_start = CNT_W'(rs);
    r.range_end   = CNT_W'(re);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick          = $urandom_range(0, 99);
    r.leaf_index  = ($urandom_range(0, 9) == 0) ? LEAF_W'($urandom)
                                                 : LEAF_W'($urandom_range(0, entries_used - 1));
    r.amount      = SUM_W'({$urandom, $urandom});
    r.range_end   = CNT_W'($urandom_range(0, entries_used));
    r.range_start = CNT_W'($urandom_range(0, r.range_end));
    if ($urandom_range(0, 99) < 15) begin
      r.range_start = CNT_W'($urandom);
      r.range_end   = CNT_W'($urandom);
    end
    if (pick < 35) begin
      r.action = ACT_WRITE;
      case ($urandom_range(0, 7))
        0:       r.amount = '0;
        1:       r.amount = SUM_W'(32'hFFFF_FFFF);
        2:       ;
        3:       r.amount = SUM_W'($urandom);
        default: r.amount = SUM_W'($urandom_range(1, 5000));
      endcase
    end else if (pick < 50) begin
      r.action = ACT_READ;
    end else if (pick < 70) begin
      r.action = ACT_RANGE;
    end else begin
      r.action = ACT_SEARCH;
      case ($urandom_range(0, 7))
        0:       r.amount = '0;
        1:       r.amount = SUM_W'(total_mass + 1);
        2:       ;
        3:       r.amount = SUM_W'(total_mass);
        default: r.amount = SUM_W'((total_mass * $urandom_range(0, 1024)) >> 10);
      endcase
    end
    return r;
  endfunction

  task automatic issue(req_t r);
    logic [PRIO_W-1:0] prio;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // shadow of the leaf priorities, only to aim search targets
    if (r.action == ACT_WRITE && r.leaf_index < entries_used) begin
      prio = (r.amount[SUM_W-1:PRIO_W] != '0) ? '1 : r.amount[PRIO_W-1:0];
      total_mass = total_mass - leaf_prio[r.leaf_index] + prio;
      leaf_prio[r.leaf_index] = prio;
    end
    sent_by_action[r.action]++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_entries(int unsigned value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CNT_W'(value);
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    entries_used = (value == 0) ? 1 : (value > LEAVES) ? LEAVES : value;
    settings_done++;
  endtask

  initial begin
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    rst_ni       = 1'b0;
    tx_idle_pct  = 19;
    rx_idle_pct  = 47;
    entries_used = LEAVES;
    total_mass   = '0;
    foreach (leaf_prio[i]) leaf_prio[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty tree, then extremes of priority, range and target
    issue(make_req(ACT_READ,   0, '0, 0, 0));
    issue(make_req(ACT_SEARCH, 0, '0, 0, 0));
    issue(make_req(ACT_SEARCH, 0, SUM_W'(1), 0, 0));
    issue(make_req(ACT_WRITE,  0, SUM_W'(5), 0, 0));
    issue(make_req(ACT_WRITE,  1023, SUM_W'(32'hFFFF_FFFF), 0, 0));
    issue(make_req(ACT_WRITE,  512, '1, 0, 0));
    issue(make_req(ACT_WRITE,  300, SUM_W'(64'h1_0000_0000), 0, 0));
    issue(make_req(ACT_WRITE,  7, '0, 0, 0));
    issue(make_req(ACT_WRITE,  1, SUM_W'(9), 0, 0));
    issue(make_req(ACT_READ,   1023, '0, 0, 0));
    issue(make_req(ACT_READ,   512, '0, 0, 0));
    issue(make_req(ACT_READ,   300, '0, 0, 0));
    issue(make_req(ACT_RANGE,  0, '0, 0, 0));
    issue(make_req(ACT_RANGE,  0, '0, 0, 1024));
    issue(make_req(ACT_RANGE,  0, '0, 1, 1023));
    issue(make_req(ACT_RANGE,  0, '0, 512, 513));
    issue(make_req(ACT_RANGE,  0, '0, 1024, 1024));
    issue(make_req(ACT_RANGE,  0, '0, 5, 3));
    issue(make_req(ACT_RANGE,  0, '0, 0, 1025));
    issue(make_req(ACT_RANGE,  0, '0, 2047, 2047));
    issue(make_req(ACT_SEARCH, 0, SUM_W'(5), 0, 0));
    issue(make_req(ACT_SEARCH, 0, SUM_W'(6), 0, 0));
    issue(make_req(ACT_SEARCH, 0, SUM_W'(total_mass), 0, 0));
    issue(make_req(ACT_SEARCH, 0, SUM_W'(total_mass + 1), 0, 0));
    issue(make_req(ACT_SEARCH, 0, '1, 0, 0));
    issue(make_req(ACT_WRITE,  0, SUM_W'(3), 0, 0));
    issue(make_req(ACT_RANGE,  0, '0, 0, 2));

    for (int p = 0; p < 6; p++) begin
      set_entries((p == 4) ? $urandom_range(2, 1023) : phase_entries[p]);
      tx_idle_pct <= (p < 2) ? 19 : (p < 4) ? 47 : 0;
      rx_idle_pct <= (p < 2) ? 47 : (p < 4) ? 19 : 0;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 4 && n == phase_items[p] / 2) settle();
        issue(random_req());
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    $display("covered %0d writes, %0d reads, %0d range sums and %0d searches",
             sent_by_action[ACT_WRITE], sent_by_action[ACT_READ],
             sent_by_action[ACT_RANGE], sent_by_action[ACT_SEARCH]);
    $display("over %0d leaf-count settings, with back-pressure on either side and none",
             settings_done);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/nsts_pkg.sv
sv/nsts_ram.sv
sv/nary_sum_tree_sampler_top.sv
sim/sum_tree_checker.sv
sim/testbench.sv
